[rtl/core/jac_pkg.sv]
package jac_pkg;

   localparam int ADC_BITS   = 14;
   localparam int AXIS_BITS  = 16;
   localparam int QUO_BITS   = 15;
   localparam int NUM_BITS   = 31;
   localparam int RAD_BITS   = 34;
   localparam int ROOT_BITS  = 32;
   localparam int CSR_ADDR_BITS = 5;

   localparam logic [30:0] SQRT2_Q30 = 31'd1518500250;

   typedef enum logic [2:0] {
      CSR_X_LOW  = 3'd0,
      CSR_X_HIGH = 3'd1,
      CSR_X_MID  = 3'd2,
      CSR_Y_LOW  = 3'd3,
      CSR_Y_HIGH = 3'd4,
      CSR_Y_MID  = 3'd5,
      CSR_DZ     = 3'd6,
      CSR_MODE   = 3'd7
   } csr_idx_type;

   typedef enum logic [1:0] {
      MC_MINUS = 2'd0,
      MC_ZERO  = 2'd1,
      MC_PLUS  = 2'd2,
      MC_DIV   = 2'd3
   } map_class_type;

   typedef struct packed {
      map_class_type      cls;
      logic               neg;
      logic [NUM_BITS-1:0] num;
      logic [15:0]        den;
   } map_prep_type;

   typedef struct packed {
      map_class_type cls;
      logic          neg;
   } map_side_type;

endpackage

[rtl/core/joystick_axis_calibration.sv]
// Calibrates one pair of 14-bit stick readings per beat into signed 16-bit X/Y positions:
// centering, optional inversion, piecewise-linear mapping between the low, center and high
// limits, optional circle-to-square mapping and a circular deadzone. The pipeline takes one
// beat every cycle while the output is not stalled, through 58 register stages. The length
// is set by the 15-stage divider and the 32-stage square root units.
// When the output beat is not taken the whole pipeline holds. Registers (4-byte apart):
// x_low_limit, x_high_limit, x_center, y_low_limit, y_high_limit, y_center,
// analog_deadzone, mode_bits (bit0 squircle, bit1 invert X, bit2 invert Y). Write them
// only while no beat is in flight.
module joystick_axis_calibration (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [31:0]                         req_tdata,   // adc_x[13:0], adc_y[27:14]
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [31:0]                         rsp_tdata,   // out_x[15:0], out_y[31:16]
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [jac_pkg::CSR_ADDR_BITS-1:0]   csr_paddr,
   input  logic [31:0]                         csr_pwdata,
   output logic [31:0]                         csr_prdata,
   output logic                                csr_pready
);
   import jac_pkg::*;

   localparam int DEPTH = 3 + QUO_BITS + 3 + ROOT_BITS + 5;

   // ---------------- configuration ----------------
   logic signed [15:0] x_low_ff, x_high_ff, x_mid_ff;
   logic signed [15:0] y_low_ff, y_high_ff, y_mid_ff;
   logic [14:0]        dz_ff;
   logic [2:0]         mode_ff;
   logic [29:0]        dz2_ff;
   csr_idx_type        csr_idx;
   logic               csr_wr;

   assign csr_idx    = csr_idx_type'(csr_paddr[4:2]);
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel & csr_penable & csr_pwrite & csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         x_low_ff  <= -16'sd32767;
         x_high_ff <= 16'sd32767;
         x_mid_ff  <= '0;
         y_low_ff  <= -16'sd32767;
         y_high_ff <= 16'sd32767;
         y_mid_ff  <= '0;
         dz_ff     <= 15'd1000;
         mode_ff   <= '0;
      end else if (csr_wr) begin
         case (csr_idx)
            CSR_X_LOW:  x_low_ff  <= csr_pwdata[15:0];
            CSR_X_HIGH: x_high_ff <= csr_pwdata[15:0];
            CSR_X_MID:  x_mid_ff  <= csr_pwdata[15:0];
            CSR_Y_LOW:  y_low_ff  <= csr_pwdata[15:0];
            CSR_Y_HIGH: y_high_ff <= csr_pwdata[15:0];
            CSR_Y_MID:  y_mid_ff  <= csr_pwdata[15:0];
            CSR_DZ:     dz_ff     <= csr_pwdata[14:0];
            CSR_MODE:   mode_ff   <= csr_pwdata[2:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      dz2_ff <= dz_ff * dz_ff;
   end

   always_comb begin
      case (csr_idx)
         CSR_X_LOW:  csr_prdata = {16'd0, x_low_ff};
         CSR_X_HIGH: csr_prdata = {16'd0, x_high_ff};
         CSR_X_MID:  csr_prdata = {16'd0, x_mid_ff};
         CSR_Y_LOW:  csr_prdata = {16'd0, y_low_ff};
         CSR_Y_HIGH: csr_prdata = {16'd0, y_high_ff};
         CSR_Y_MID:  csr_prdata = {16'd0, y_mid_ff};
         CSR_DZ:     csr_prdata = {17'd0, dz_ff};
         CSR_MODE:   csr_prdata = {29'd0, mode_ff};
         default:    csr_prdata = '0;
      endcase
   end

   // ---------------- helpers ----------------
   function automatic logic signed [15:0] scale_axis(input logic [13:0] adc, input logic inv);
      logic signed [17:0] v;
      v = $signed({4'b0, adc}) - 18'sd8192;
      if (inv) v = -v;
      v = v <<< 2;
      if (v > 18'sd32767) v = 18'sd32767;
      return v[15:0];
   endfunction

   function automatic map_prep_type map_prep(input logic signed [15:0] in,
                                             input logic signed [15:0] low,
                                             input logic signed [15:0] mid,
                                             input logic signed [15:0] high);
      map_prep_type       p;
      logic signed [16:0] dm;
      logic signed [16:0] dn;
      logic [15:0]        diff;
      p.neg = in < mid;
      dm = p.neg ? 17'(mid) - 17'(in) : 17'(in) - 17'(mid);
      dn = p.neg ? 17'(mid) - 17'(low) : 17'(high) - 17'(mid);
      diff  = dm[15:0];
      p.den = dn[15:0];
      p.num = {diff, 15'b0} - {15'b0, diff};
      if (in <= low)       p.cls = MC_MINUS;
      else if (in == mid)  p.cls = MC_ZERO;
      else if (in >= high) p.cls = MC_PLUS;
      else                 p.cls = MC_DIV;
      return p;
   endfunction

   function automatic logic signed [15:0] map_final(input map_side_type s,
                                                    input logic [QUO_BITS-1:0] q);
      logic signed [15:0] r;
      case (s.cls)
         MC_MINUS: r = -16'sd32768;
         MC_ZERO:  r = '0;
         MC_PLUS:  r = 16'sd32767;
         default:  r = s.neg ? -$signed({1'b0, q}) : $signed({1'b0, q});
      endcase
      return r;
   endfunction

   function automatic logic [RAD_BITS-1:0] clamp_rad(input logic signed [35:0] v);
      return v[35] ? '0 : v[RAD_BITS-1:0];
   endfunction

   // ---------------- pipeline control ----------------
   logic             adv;
   logic [DEPTH-1:0] vld_ff;

   assign adv        = ~vld_ff[DEPTH-1] | rsp_tready;
   assign req_tready = adv;
   assign rsp_tvalid = vld_ff[DEPTH-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= {vld_ff[DEPTH-2:0], req_tvalid};
      end
   end

   // P0 input, P1 scale, P2 map setup
   logic [13:0]        adc_x_ff, adc_y_ff;
   logic signed [15:0] sx_ff, sy_ff;
   map_prep_type       px_ff, py_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         adc_x_ff <= req_tdata[13:0];
         adc_y_ff <= req_tdata[27:14];
         sx_ff    <= scale_axis(adc_x_ff, mode_ff[1]);
         sy_ff    <= scale_axis(adc_y_ff, mode_ff[2]);
         px_ff    <= map_prep(sx_ff, x_low_ff, x_mid_ff, x_high_ff);
         py_ff    <= map_prep(sy_ff, y_low_ff, y_mid_ff, y_high_ff);
      end
   end

   // dividers with class/sign carried alongside
   logic [QUO_BITS-1:0] qx, qy;
   map_side_type        sdx_ff [QUO_BITS];
   map_side_type        sdy_ff [QUO_BITS];

   jac_div_pipe u_div_x (.clock(clock), .adv(adv), .num(px_ff.num), .den(px_ff.den), .quo(qx));
   jac_div_pipe u_div_y (.clock(clock), .adv(adv), .num(py_ff.num), .den(py_ff.den), .quo(qy));

   always_ff @(posedge clock) begin
      if (adv) begin
         sdx_ff[0] <= '{cls: px_ff.cls, neg: px_ff.neg};
         sdy_ff[0] <= '{cls: py_ff.cls, neg: py_ff.neg};
         for (int i = 1; i < QUO_BITS; i++) begin
            sdx_ff[i] <= sdx_ff[i-1];
            sdy_ff[i] <= sdy_ff[i-1];
         end
      end
   end

   // P3 mapped, P4 products, P5 radicands
   logic signed [15:0] mx_ff, my_ff, m4x_ff, m4y_ff, m5x_ff, m5y_ff;
   logic [30:0]        x2_ff, y2_ff;
   logic [46:0]        tx_ff, ty_ff;
   logic [RAD_BITS-1:0] rax_ff, rbx_ff, ray_ff, rby_ff;
   logic [15:0]        magx, magy;
   logic [16:0]        magx_w, magy_w;
   logic signed [31:0] x2_w, y2_w;
   logic signed [35:0] base_x, base_y, tsx, tsy;

   always_comb begin
      magx_w = mx_ff[15] ? -{mx_ff[15], mx_ff} : {mx_ff[15], mx_ff};
      magy_w = my_ff[15] ? -{my_ff[15], my_ff} : {my_ff[15], my_ff};
      magx   = magx_w[15:0];
      magy   = magy_w[15:0];
      x2_w   = mx_ff * mx_ff;
      y2_w   = my_ff * my_ff;
      base_x = 36'sh080000000 + $signed({5'b0, x2_ff}) - $signed({5'b0, y2_ff});
      base_y = 36'sh080000000 + $signed({5'b0, y2_ff}) - $signed({5'b0, x2_ff});
      tsx    = $signed({3'b0, tx_ff[46:14]});
      tsy    = $signed({3'b0, ty_ff[46:14]});
      if (m4x_ff[15]) tsx = -tsx;
      if (m4y_ff[15]) tsy = -tsy;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         mx_ff  <= map_final(sdx_ff[QUO_BITS-1], qx);
         my_ff  <= map_final(sdy_ff[QUO_BITS-1], qy);
         m4x_ff <= mx_ff;
         m4y_ff <= my_ff;
         x2_ff  <= x2_w[30:0];
         y2_ff  <= y2_w[30:0];
         tx_ff  <= SQRT2_Q30 * magx;
         ty_ff  <= SQRT2_Q30 * magy;
         m5x_ff <= m4x_ff;
         m5y_ff <= m4y_ff;
         rax_ff <= clamp_rad(base_x + tsx);
         rbx_ff <= clamp_rad(base_x - tsx);
         ray_ff <= clamp_rad(base_y + tsy);
         rby_ff <= clamp_rad(base_y - tsy);
      end
   end

   // square roots, mapped values carried alongside
   logic [ROOT_BITS-1:0] sax, sbx, say, sby;
   logic signed [15:0]   cx_ff [ROOT_BITS];
   logic signed [15:0]   cy_ff [ROOT_BITS];

   jac_sqrt_pipe u_sqrt_ax (.clock(clock), .adv(adv), .rad(rax_ff), .root(sax));
   jac_sqrt_pipe u_sqrt_bx (.clock(clock), .adv(adv), .rad(rbx_ff), .root(sbx));
   jac_sqrt_pipe u_sqrt_ay (.clock(clock), .adv(adv), .rad(ray_ff), .root(say));
   jac_sqrt_pipe u_sqrt_by (.clock(clock), .adv(adv), .rad(rby_ff), .root(sby));

   always_ff @(posedge clock) begin
      if (adv) begin
         cx_ff[0] <= m5x_ff;
         cy_ff[0] <= m5y_ff;
         for (int i = 1; i < ROOT_BITS; i++) begin
            cx_ff[i] <= cx_ff[i-1];
            cy_ff[i] <= cy_ff[i-1];
         end
      end
   end

   // P6 root difference, P7 scale, P8 clip and select
   logic signed [32:0] dfx, dfy;
   logic [32:0]        dmx_ff, dmy_ff;
   logic               dnx_ff, dny_ff, dnx7_ff, dny7_ff;
   logic [47:0]        prx_ff, pry_ff;
   logic signed [15:0] c6x_ff, c6y_ff, c7x_ff, c7y_ff, fx_ff, fy_ff;
   logic [16:0]        rx, ry;
   logic [15:0]        rcx, rcy;
   logic signed [15:0] qsx, qsy;

   always_comb begin
      dfx = $signed({1'b0, sax}) - $signed({1'b0, sbx});
      dfy = $signed({1'b0, say}) - $signed({1'b0, sby});
      rx  = prx_ff[47:31];
      ry  = pry_ff[47:31];
      rcx = (rx > 17'd32767) ? 16'd32767 : rx[15:0];
      rcy = (ry > 17'd32767) ? 16'd32767 : ry[15:0];
      qsx = dnx7_ff ? -$signed(rcx) : $signed(rcx);
      qsy = dny7_ff ? -$signed(rcy) : $signed(rcy);
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         dnx_ff  <= dfx[32];
         dny_ff  <= dfy[32];
         dmx_ff  <= dfx[32] ? 33'(-dfx) : 33'(dfx);
         dmy_ff  <= dfy[32] ? 33'(-dfy) : 33'(dfy);
         c6x_ff  <= cx_ff[ROOT_BITS-1];
         c6y_ff  <= cy_ff[ROOT_BITS-1];
         prx_ff  <= dmx_ff * 15'd32767;
         pry_ff  <= dmy_ff * 15'd32767;
         dnx7_ff <= dnx_ff;
         dny7_ff <= dny_ff;
         c7x_ff  <= c6x_ff;
         c7y_ff  <= c6y_ff;
         fx_ff   <= mode_ff[0] ? qsx : c7x_ff;
         fy_ff   <= mode_ff[0] ? qsy : c7y_ff;
      end
   end

   // P9 squares, P10 deadzone and output
   logic signed [31:0] fx2_w, fy2_w;
   logic [30:0]        fx2_ff, fy2_ff;
   logic signed [15:0] gx_ff, gy_ff, ox_ff, oy_ff;
   logic [31:0]        r2;

   assign fx2_w = fx_ff * fx_ff;
   assign fy2_w = fy_ff * fy_ff;
   assign r2    = {1'b0, fx2_ff} + {1'b0, fy2_ff};

   always_ff @(posedge clock) begin
      if (adv) begin
         fx2_ff <= fx2_w[30:0];
         fy2_ff <= fy2_w[30:0];
         gx_ff  <= fx_ff;
         gy_ff  <= fy_ff;
         ox_ff  <= (r2 < {2'b0, dz2_ff}) ? '0 : gx_ff;
         oy_ff  <= (r2 < {2'b0, dz2_ff}) ? '0 : gy_ff;
      end
   end

   assign rsp_tdata = {oy_ff, ox_ff};

endmodule

[rtl/core/jac_div_pipe.sv]
module jac_div_pipe (
   input  logic                          clock,
   input  logic                          adv,
   input  logic [jac_pkg::NUM_BITS-1:0]  num,
   input  logic [15:0]                   den,
   output logic [jac_pkg::QUO_BITS-1:0]  quo
);
   import jac_pkg::*;

   logic [NUM_BITS-1:0] rem_ff [QUO_BITS];
   logic [15:0]         den_ff [QUO_BITS];
   logic [QUO_BITS-1:0] quo_ff [QUO_BITS];

   // one quotient bit per stage, msb first
   for (genvar k = 0; k < QUO_BITS; k++) begin : g_stage
      logic [NUM_BITS-1:0] rem_src;
      logic [15:0]         den_src;
      logic [QUO_BITS-1:0] quo_src;
      logic [NUM_BITS-1:0] sub;
      logic                ge;

      if (k == 0) begin : g_first
         assign rem_src = num;
         assign den_src = den;
         assign quo_src = '0;
      end else begin : g_next
         assign rem_src = rem_ff[k-1];
         assign den_src = den_ff[k-1];
         assign quo_src = quo_ff[k-1];
      end

      assign sub = {{(NUM_BITS-16){1'b0}}, den_src} << (QUO_BITS-1-k);
      assign ge  = rem_src >= sub;

      always_ff @(posedge clock) begin
         if (adv) begin
            rem_ff[k] <= ge ? rem_src - sub : rem_src;
            den_ff[k] <= den_src;
            quo_ff[k] <= {quo_src[QUO_BITS-2:0], ge};
         end
      end
   end

   assign quo = quo_ff[QUO_BITS-1];

endmodule

[rtl/core/jac_sqrt_pipe.sv]
module jac_sqrt_pipe (
   input  logic                           clock,
   input  logic                           adv,
   input  logic [jac_pkg::RAD_BITS-1:0]   rad,
   output logic [jac_pkg::ROOT_BITS-1:0]  root
);
   import jac_pkg::*;

   localparam int XW = 2 * ROOT_BITS;
   localparam int RW = ROOT_BITS + 4;

   logic [XW-1:0]        x_ff    [ROOT_BITS];
   logic [RW-1:0]        rem_ff  [ROOT_BITS];
   logic [ROOT_BITS-1:0] root_ff [ROOT_BITS];

   // floor root of rad * 2^30, one result bit per stage
   for (genvar k = 0; k < ROOT_BITS; k++) begin : g_stage
      logic [XW-1:0]        x_src;
      logic [RW-1:0]        rem_src;
      logic [ROOT_BITS-1:0] root_src;
      logic [RW-1:0]        cur;
      logic [RW-1:0]        trial;
      logic                 ge;

      if (k == 0) begin : g_first
         assign x_src    = {rad, {(XW-RAD_BITS){1'b0}}};
         assign rem_src  = '0;
         assign root_src = '0;
      end else begin : g_next
         assign x_src    = x_ff[k-1];
         assign rem_src  = rem_ff[k-1];
         assign root_src = root_ff[k-1];
      end

      assign cur   = {rem_src[RW-3:0], x_src[XW-1:XW-2]};
      assign trial = {2'b00, root_src, 2'b01};
      assign ge    = cur >= trial;

      always_ff @(posedge clock) begin
         if (adv) begin
            x_ff[k]    <= {x_src[XW-3:0], 2'b00};
            rem_ff[k]  <= ge ? cur - trial : cur;
            root_ff[k] <= {root_src[ROOT_BITS-2:0], ge};
         end
      end
   end

   assign root = root_ff[ROOT_BITS-1];

endmodule

[tb/joystick_axis_calibration_checker.sv]
module joystick_axis_calibration_checker (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   input  logic                              req_tready,
   input  logic [31:0]                       req_tdata,   // adc_x[13:0], adc_y[27:14]
   input  logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   input  logic [31:0]                       rsp_tdata,   // out_x[15:0], out_y[31:16]
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [jac_pkg::CSR_ADDR_BITS-1:0] csr_paddr,
   input  logic [31:0]                       csr_pwdata,
   input  logic                              csr_pready,
   output int                                errors,
   output int                                pending,
   output int                                positions_seen
);
   timeunit 1ns;
   timeprecision 1ps;
   import jac_pkg::*;

   typedef struct packed {
      logic signed [15:0] y;
      logic signed [15:0] x;
   } position_type;

   int x_low, x_high, x_mid, y_low, y_high, y_mid, deadzone;
   logic [2:0] mode;
   position_type expected_positions[$];

   task automatic report_mismatch(input string what, input int got, input int want);
      $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
      errors++;
   endtask

   function automatic int scale_reading(input logic [13:0] raw, input logic inv);
      int v;
      v = int'(raw) - 8192;
      if (inv) v = -v;
      v = v * 4;
      if (v < -32768) v = -32768;
      if (v > 32767) v = 32767;
      return v;
   endfunction

   function automatic int map_linear(input int v, input int lo, input int mid, input int hi);
      longint d, a;
      if (v <= lo) return -32768;
      if (v == mid) return 0;
      if (v >= hi) return 32767;
      if (v < mid) begin
         d = longint'(mid) - lo;
         a = longint'(v) - lo;
         return int'(-(((d - a) * 32767) / d));
      end
      return int'(((longint'(v) - mid) * 32767) / (longint'(hi) - mid));
   endfunction

   function automatic longint unsigned floor_sqrt(input longint unsigned n);
      longint unsigned root, b;
      root = 0;
      b = 64'd1 << 62;
      while (b > n) b = b >> 2;
      while (b != 0) begin
         if (n >= root + b) begin
            n = n - (root + b);
            root = (root >> 1) + b;
         end else begin
            root = root >> 1;
         end
         b = b >> 2;
      end
      return root;
   endfunction

   function automatic int square_axis(input int p, input int q);
      longint mag, t, base, ra, rb, sa, sb, diff, dmag, r;
      mag = (p < 0) ? -p : p;
      t = (longint'(SQRT2_Q30) * mag) / 16384;
      if (p < 0) t = -t;
      base = (longint'(1) << 31) + longint'(p) * p - longint'(q) * q;
      ra = base + t;
      rb = base - t;
      if (ra < 0) ra = 0;
      if (rb < 0) rb = 0;
      sa = longint'(floor_sqrt(longint'(ra) << 30));
      sb = longint'(floor_sqrt(longint'(rb) << 30));
      diff = sa - sb;
      dmag = (diff < 0) ? -diff : diff;
      r = (dmag * 32767) / (longint'(1) << 31);
      if (diff < 0) r = -r;
      if (r > 32767) r = 32767;
      if (r < -32767) r = -32767;
      return int'(r);
   endfunction

   function automatic position_type calibrate(input logic [13:0] ax, input logic [13:0] ay);
      int x, y, nx, ny;
      longint r2;
      position_type pos;
      x = map_linear(scale_reading(ax, mode[1]), x_low, x_mid, x_high);
      y = map_linear(scale_reading(ay, mode[2]), y_low, y_mid, y_high);
      if (mode[0]) begin
         nx = square_axis(x, y);
         ny = square_axis(y, x);
         x = nx;
         y = ny;
      end
      if (deadzone != 0) begin
         r2 = longint'(x) * x + longint'(y) * y;
         if (r2 < longint'(deadzone) * deadzone) begin
            x = 0;
            y = 0;
         end
      end
      pos.x = x[15:0];
      pos.y = y[15:0];
      return pos;
   endfunction

   assign pending = expected_positions.size();

   initial begin
      errors = 0;
      positions_seen = 0;
   end

   always @(posedge clock) begin
      position_type want, got;
      if (reset) begin
         x_low <= -32767; x_high <= 32767; x_mid <= 0;
         y_low <= -32767; y_high <= 32767; y_mid <= 0;
         deadzone <= 1000;
         mode <= 3'd0;
         expected_positions.delete();
      end else begin
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            case (csr_idx_type'(csr_paddr[4:2]))
               CSR_X_LOW:  x_low <= int'($signed(csr_pwdata[15:0]));
               CSR_X_HIGH: x_high <= int'($signed(csr_pwdata[15:0]));
               CSR_X_MID:  x_mid <= int'($signed(csr_pwdata[15:0]));
               CSR_Y_LOW:  y_low <= int'($signed(csr_pwdata[15:0]));
               CSR_Y_HIGH: y_high <= int'($signed(csr_pwdata[15:0]));
               CSR_Y_MID:  y_mid <= int'($signed(csr_pwdata[15:0]));
               CSR_DZ:     deadzone <= int'(csr_pwdata[14:0]);
               CSR_MODE:   mode <= csr_pwdata[2:0];
               default: ;
            endcase
         end
         if (rsp_tvalid && rsp_tready) begin
            got = rsp_tdata;
            positions_seen++;
            if (expected_positions.size() == 0) begin
               report_mismatch("unexpected beat, out_x", int'(got.x), 0);
            end else begin
               want = expected_positions.pop_front();
               if (got.x !== want.x) report_mismatch("out_x", int'(got.x), int'(want.x));
               if (got.y !== want.y) report_mismatch("out_y", int'(got.y), int'(want.y));
            end
         end
         if (req_tvalid && req_tready)
            expected_positions.push_back(calibrate(req_tdata[13:0], req_tdata[27:14]));
      end
   end

endmodule

[tb/tb_joystick_axis_calibration.sv]
module tb_joystick_axis_calibration;
   timeunit 1ns;
   timeprecision 1ps;
   import jac_pkg::*;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;
   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [CSR_ADDR_BITS-1:0] csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   int errors, pending, positions_seen;
   int beats_sent = 0;
   int settings_used = 0;
   int stall_level = 1;
   int hold_cycles = 0;
   bit steady = 0;

   joystick_axis_calibration dut (.*);

   joystick_axis_calibration_checker checker_i (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   initial begin
      #20ms;
      $display("FAIL joystick_axis_calibration");
      $finish;
   end

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (steady || r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // result side backpressure, mostly short stalls and a few long ones
   always @(posedge clock) begin
      int r;
      r = $urandom_range(0, 99);
      if (steady || stall_level == 0) begin
         rsp_tready <= 1'b1;
         hold_cycles <= 0;
      end else if (hold_cycles > 0) begin
         rsp_tready <= 1'b0;
         hold_cycles <= hold_cycles - 1;
      end else if (r < 8 * stall_level) begin
         rsp_tready <= 1'b0;
      end else if (r < 8 * stall_level + 2) begin
         rsp_tready <= 1'b0;
         hold_cycles <= $urandom_range(10, 40);
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   task automatic send_reading(input logic [13:0] ax, input logic [13:0] ay);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {4'b0, ay, ax};
      do @(posedge clock); while (!req_tready);
      beats_sent++;
   endtask

   task automatic wait_drained();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
   endtask

   task automatic write_reg(input csr_idx_type idx, input int value);
      csr_psel <= 1'b1;
      csr_pwrite <= 1'b1;
      csr_penable <= 1'b0;
      csr_paddr <= CSR_ADDR_BITS'(idx) << 2;
      csr_pwdata <= 32'(value);
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
   endtask

   task automatic apply_setting(input int xl, input int xh, input int xm, input int yl,
                                input int yh, input int ym, input int dz, input int md);
      write_reg(CSR_X_LOW, xl);
      write_reg(CSR_X_HIGH, xh);
      write_reg(CSR_X_MID, xm);
      write_reg(CSR_Y_LOW, yl);
      write_reg(CSR_Y_HIGH, yh);
      write_reg(CSR_Y_MID, ym);
      write_reg(CSR_DZ, dz);
      write_reg(CSR_MODE, md);
      @(posedge clock);
      settings_used++;
   endtask

   function automatic int rand_limit();
      int r;
      r = $urandom_range(0, 9);
      if (r == 0) return -32768;
      if (r == 1) return 32767;
      return int'($signed(16'($urandom)));
   endfunction

   function automatic logic [13:0] rand_reading();
      int r;
      r = $urandom_range(0, 9);
      if (r == 0) return 14'($urandom_range(0, 1)) * 14'd16383;
      if (r < 3) return 14'($urandom_range(8192 - 300, 8192 + 300));
      return 14'($urandom);
   endfunction

   task automatic directed_batch();
      send_reading(14'd0, 14'd0);
      send_reading(14'd16383, 14'd16383);
      send_reading(14'd8192, 14'd8192);
      send_reading(14'd0, 14'd16383);
      send_reading(14'd16383, 14'd0);
      send_reading(14'd8192 + 14'd100, 14'd8192);
      send_reading(14'd8192 + 14'd300, 14'd8192 - 14'd300);
      send_reading(14'h2AAA, 14'h1555);
      send_reading(14'h1555, 14'h2AAA);
   endtask

   initial begin
      int xm, ym, xl, xh, yl, yh;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset values first, then squircle with both inversions
      steady = 1;
      directed_batch();
      wait_drained();
      apply_setting(-32767, 32767, 0, -32767, 32767, 0, 0, 7);
      directed_batch();
      wait_drained();
      // extreme limits, inconsistent order, full deadzone
      apply_setting(-32768, -32768, -32768, 32767, -32768, 32767, 32767, 1);
      send_reading(14'd0, 14'd16383);
      send_reading(14'd16383, 14'd0);
      send_reading(14'd8192, 14'd8192);
      wait_drained();
      steady = 0;

      for (int ph = 0; ph < 10; ph++) begin
         stall_level = ph % 4;
         steady = (ph == 3);
         if (ph % 3 == 0) begin
            apply_setting(-32768, 32767, 0, -32768, 32767, 0,
                          (ph == 0) ? 32767 : $urandom_range(0, 3000), $urandom_range(0, 7));
         end else begin
            xm = int'($signed(16'($urandom_range(0, 20000) - 10000)));
            ym = int'($signed(16'($urandom_range(0, 20000) - 10000)));
            xl = ($urandom_range(0, 4) == 0) ? rand_limit() : xm - $urandom_range(1, 22000);
            xh = ($urandom_range(0, 4) == 0) ? rand_limit() : xm + $urandom_range(1, 22000);
            yl = ($urandom_range(0, 4) == 0) ? rand_limit() : ym - $urandom_range(1, 22000);
            yh = ($urandom_range(0, 4) == 0) ? rand_limit() : ym + $urandom_range(1, 22000);
            if (xl < -32768) xl = -32768;
            if (xh > 32767) xh = 32767;
            if (yl < -32768) yl = -32768;
            if (yh > 32767) yh = 32767;
            apply_setting(xl, xh, xm, yl, yh, ym,
                          ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6000),
                          $urandom_range(0, 7));
         end
         for (int i = 0; i < 200; i++) begin
            // sender holds off once mid phase until the pipeline is empty
            if (ph == 5 && i == 100) wait_drained();
            send_reading(rand_reading(), rand_reading());
         end
         wait_drained();
      end

      repeat (80) @(posedge clock);
      $display("sent %0d readings over %0d register settings, %0d positions checked",
               beats_sent, settings_used, positions_seen);
      if (errors == 0 && pending == 0) begin
         $display("PASS joystick_axis_calibration");
      end else begin
         $display("FAIL joystick_axis_calibration");
      end
      $finish;
   end

endmodule

[filelist.f]
rtl/core/jac_pkg.sv
rtl/core/jac_div_pipe.sv
rtl/core/jac_sqrt_pipe.sv
rtl/core/joystick_axis_calibration.sv
tb/joystick_axis_calibration_checker.sv
tb/tb_joystick_axis_calibration.sv
